FILE: rtl/nibble_match_cipher_nlfsr_unit_macros.svh
// assertion macros shared by the cipher unit (sampled on clk, disabled while arst_n is low)
`ifndef NIBBLE_MATCH_CIPHER_NLFSR_UNIT_MACROS_SVH
`define NIBBLE_MATCH_CIPHER_NLFSR_UNIT_MACROS_SVH

// same-cycle implication
`define NMC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NMC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/nmc_pkg.sv
// shared constants, types and table functions of the nibble match cipher
`default_nettype none
package nmc_pkg;

	// keystream register geometry and feedback taps
	localparam int unsigned REG_BITS = 24;
	localparam logic [REG_BITS-1:0] LIN_TAPS = 24'h008303;
	localparam logic [REG_BITS-1:0] KEY_RESET = 24'hAAAAAA;

	// fail counter and result cap
	localparam int unsigned FAIL_LIMIT_DEF = 32;
	localparam int unsigned FAIL_W = 5;
	localparam int unsigned MAX_RESULTS = 64;
	localparam int unsigned RES_W = 6;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECIPHER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECRET_KEY = 1'b1;

	// codeword values
	localparam logic [7:0] CODE_OVERFLOW = 8'hFF;
	localparam logic [2:0] CODE_MAX_VALID = 3'd4;

	// one result transfer
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       error_flag;
	} result_t;

	// four register steps; the keystream nibble of these steps is s[4:1]
	function automatic logic [REG_BITS-1:0] nlfsr_step4(input logic [REG_BITS-1:0] s);
		logic [REG_BITS-1:0] r;
		logic fb;
		r = s;
		for (int i = 0; i < 4; i++) begin
			fb = (^(r & LIN_TAPS)) ^ (r[17] & r[18]);
			r = {fb, r[REG_BITS-1:1]};
		end
		return r;
	endfunction

	// difference of weight zero or one
	function automatic logic near_f(input logic [3:0] diff);
		unique case (diff)
			4'h0, 4'h1, 4'h2, 4'h4, 4'h8: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// discrepancy code of a near difference
	function automatic logic [2:0] code_of_diff_f(input logic [3:0] diff);
		unique case (diff)
			4'h1: return 3'd1;
			4'h2: return 3'd2;
			4'h4: return 3'd3;
			4'h8: return 3'd4;
			default: return 3'd0;
		endcase
	endfunction

	// correction nibble of a discrepancy code
	function automatic logic [3:0] diff_of_code_f(input logic [2:0] code);
		unique case (code)
			3'd1: return 4'h1;
			3'd2: return 4'h2;
			3'd3: return 4'h4;
			3'd4: return 4'h8;
			default: return 4'h0;
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: rtl/nmc_nlfsr.sv
// keystream generator: 24-bit nonlinear shift register advanced one nibble per cycle while advance is high
`default_nettype none
module nmc_nlfsr (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load,
	input  wire logic [nmc_pkg::REG_BITS-1:0] key,
	input  wire logic                         advance,
	output logic      [3:0]                   nib,
	output logic      [nmc_pkg::REG_BITS-1:0] ks_state
);
	import nmc_pkg::*;

	logic [REG_BITS-1:0] ks_q;

	// reload on message start, otherwise four steps per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q <= KEY_RESET;
		end else if (load) begin
			ks_q <= key;
		end else if (advance) begin
			ks_q <= nlfsr_step4(ks_q);
		end
	end

	// first keystream bit in the lsb
	assign nib      = ks_q[4:1];
	assign ks_state = ks_q;

endmodule
`default_nettype wire

FILE: rtl/nmc_outreg.sv
// output holding register between the sequencer and the result channel
`default_nettype none
module nmc_outreg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire nmc_pkg::result_t din,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output nmc_pkg::result_t      dout,
	output logic                  free
);
	import nmc_pkg::*;

	logic    valid_q;
	result_t data_q;

	// slot can take a result when empty or being drained this cycle
	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign out_valid = valid_q;
	assign dout      = data_q;

endmodule
`default_nettype wire

FILE: rtl/nibble_match_cipher_nlfsr_unit.sv
// top level of the nibble match byte cipher with its sequencer and config registers
//
// Input channel in_valid/in_ready carries in_byte and start_message; a set
// start_message reloads the keystream register from secret_key and clears the
// nibble phase before the byte is worked on. in_ready is high only while the
// sequencer is idle, so one byte is in work at a time.
// Result channel out_valid/out_ready carries out_byte, last_of_run, error_flag
// from a one-entry output register; the next byte is taken while a result waits.
// Config: cfg_we writes cfg_data into register cfg_index (0 decipher select,
// 1 secret_key) at once; write only while idle.
// Timing: the keystream register yields one nibble per cycle while the sequencer
// is in a mask, draw or discard state. A nibble of encrypt passes S_MASK_HI,
// S_MASK_LO, S_ENC_DRAW until a match (about 3.2 draws per match) and S_EMIT;
// an overflow codeword adds S_EMIT and a fresh mask. A decrypt byte passes
// S_IDLE, both mask states and S_DEC_DRAW up to the fail count in its codeword,
// plus S_EMIT on the low nibble; an overflow codeword runs S_DISCARD for
// FAIL_LIMIT nibbles. A stalled receiver holds S_EMIT until the output register frees up.
// Reset clears all state but the output payload; secret_key returns to 0xAAAAAA, the mode to encrypt.
`default_nettype none
`include "nibble_match_cipher_nlfsr_unit_macros.svh"
module nibble_match_cipher_nlfsr_unit #(
	parameter int unsigned FAIL_LIMIT = nmc_pkg::FAIL_LIMIT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          start_message,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [7:0]                    out_byte,
	output logic                               last_of_run,
	output logic                               error_flag,
	input  wire logic                          cfg_we,
	input  wire logic [nmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nmc_pkg::REG_BITS-1:0]  cfg_data
);
	import nmc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MASK_HI,
		S_MASK_LO,
		S_ENC_DRAW,
		S_DEC_DRAW,
		S_DISCARD,
		S_EMIT
	} state_t;

	// configuration registers
	logic                decipher_q;
	logic [REG_BITS-1:0] secret_key_q;

	// sequencer state
	state_t            state_q;
	state_t            nxt_q;
	logic [7:0]        byte_q;
	logic [7:0]        mask_q;
	logic [7:0]        code_q;
	logic [FAIL_W-1:0] cnt_q;
	logic              half_q;
	logic              dead_q;
	logic [RES_W-1:0]  res_cnt_q;
	logic              phase_q;
	logic [3:0]        held_q;
	logic              held_err_q;
	result_t           pend_q;

	// datapath wires
	logic                in_xfer;
	logic                ks_load;
	logic                ks_adv;
	logic [3:0]          nib;
	logic [REG_BITS-1:0] ks_state;
	logic [7:0]          code_now;
	logic [3:0]          x_nib;
	logic [3:0]          diff;
	logic                is_near;
	logic [7:0]          enc_val;
	logic [7:0]          ovf_val;
	logic [2:0]          dcode;
	logic                bad_code;
	logic [3:0]          xn;
	logic                last_fail;
	logic                cap_hit;
	logic                out_free;
	logic                out_load;
	result_t             out_data;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign ks_load  = in_xfer && start_message;
	assign ks_adv   = (state_q == S_MASK_HI) || (state_q == S_MASK_LO)
		|| (state_q == S_ENC_DRAW) || (state_q == S_DEC_DRAW) || (state_q == S_DISCARD);
	assign out_load = (state_q == S_EMIT) && out_free;

	nmc_nlfsr u_nlfsr (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ks_load),
		.key      (secret_key_q),
		.advance  (ks_adv),
		.nib      (nib),
		.ks_state (ks_state)
	);

	nmc_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.din       (pend_q),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.dout      (out_data),
		.free      (out_free)
	);

	assign out_byte    = out_data.out_byte;
	assign last_of_run = out_data.last_of_run;
	assign error_flag  = out_data.error_flag;

	// per-nibble datapath
	always_comb begin
		code_now  = byte_q ^ {mask_q[7:4], nib};
		x_nib     = half_q ? byte_q[3:0] : byte_q[7:4];
		diff      = x_nib ^ nib;
		is_near   = near_f(diff);
		enc_val   = {cnt_q, code_of_diff_f(diff)} ^ mask_q;
		ovf_val   = CODE_OVERFLOW ^ mask_q;
		dcode     = code_q[2:0];
		bad_code  = dcode > CODE_MAX_VALID;
		xn        = bad_code ? nib : (nib ^ diff_of_code_f(dcode));
		last_fail = cnt_q == FAIL_W'(FAIL_LIMIT - 1);
		cap_hit   = res_cnt_q == RES_W'(MAX_RESULTS - 1);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decipher_q   <= 1'b0;
			secret_key_q <= KEY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DECIPHER:   decipher_q   <= cfg_data[0];
				CFG_SECRET_KEY: secret_key_q <= cfg_data;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			nxt_q      <= S_IDLE;
			byte_q     <= '0;
			mask_q     <= '0;
			code_q     <= '0;
			cnt_q      <= '0;
			half_q     <= 1'b0;
			dead_q     <= 1'b0;
			res_cnt_q  <= '0;
			phase_q    <= 1'b0;
			held_q     <= '0;
			held_err_q <= 1'b0;
			pend_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						byte_q    <= in_byte;
						half_q    <= 1'b0;
						dead_q    <= 1'b0;
						res_cnt_q <= '0;
						if (start_message) begin
							phase_q    <= 1'b0;
							held_q     <= '0;
							held_err_q <= 1'b0;
						end
						state_q <= S_MASK_HI;
					end
				end
				S_MASK_HI: begin
					mask_q[7:4] <= nib;
					state_q     <= S_MASK_LO;
				end
				S_MASK_LO: begin
					mask_q[3:0] <= nib;
					cnt_q       <= '0;
					if (!decipher_q) begin
						state_q <= S_ENC_DRAW;
					end else if (code_now == CODE_OVERFLOW) begin
						state_q <= S_DISCARD;
					end else begin
						code_q  <= code_now;
						state_q <= S_DEC_DRAW;
					end
				end
				S_ENC_DRAW: begin
					priority if (is_near) begin
						// match: result of this nibble, or stop past the cap
						cnt_q <= '0;
						if (dead_q) begin
							state_q <= S_IDLE;
						end else begin
							pend_q.out_byte    <= enc_val;
							pend_q.last_of_run <= half_q || cap_hit;
							pend_q.error_flag  <= cap_hit && !half_q;
							dead_q             <= cap_hit && !half_q;
							res_cnt_q          <= res_cnt_q + 1'b1;
							half_q             <= 1'b1;
							nxt_q              <= half_q ? S_IDLE : S_MASK_HI;
							state_q            <= S_EMIT;
						end
					end else if (last_fail) begin
						// fail limit reached: overflow codeword, then a fresh mask
						cnt_q <= '0;
						if (dead_q) begin
							state_q <= S_IDLE;
						end else begin
							pend_q.out_byte    <= ovf_val;
							pend_q.last_of_run <= cap_hit;
							pend_q.error_flag  <= cap_hit;
							dead_q             <= cap_hit;
							res_cnt_q          <= res_cnt_q + 1'b1;
							nxt_q              <= S_MASK_HI;
							state_q            <= S_EMIT;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DEC_DRAW: begin
					if (cnt_q == code_q[7:3]) begin
						if (!phase_q) begin
							held_q     <= xn;
							held_err_q <= bad_code;
							phase_q    <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							pend_q.out_byte    <= {held_q, xn};
							pend_q.last_of_run <= 1'b1;
							pend_q.error_flag  <= bad_code || held_err_q;
							phase_q            <= 1'b0;
							held_err_q         <= 1'b0;
							nxt_q              <= S_IDLE;
							state_q            <= S_EMIT;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DISCARD: begin
					// overflow codeword skips a full run of keystream nibbles
					if (last_fail) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= nxt_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`NMC_ASSERT_IMP(a_err_is_last, out_valid && error_flag, last_of_run, "error result not last of run")
	`NMC_ASSERT_IMP(a_cap_result_flagged, state_q == S_EMIT && dead_q, pend_q.error_flag && pend_q.last_of_run, "capped result lacks error and last")
	`NMC_ASSERT_NXT(a_key_reload, ks_load, ks_state == $past(secret_key_q), "keystream not reloaded from key")

endmodule
`default_nettype wire
